// ===== rtl/pqe_pkg.sv =====
`default_nettype none
package pqe_pkg;

    // Fixed-point format of all logs and powers
    localparam int QB = 30;

    // Default parameter values and fixed field widths
    localparam int DEF_IN_FRAC_BITS = 10;
    localparam int DEF_OUT_BITS     = 12;
    localparam int NITS_W           = 24;

    // Pipeline depths of the arithmetic units
    localparam int LOG_LAT  = QB + 2;
    localparam int EXP_LAT  = QB + 1;
    localparam int LANE_LAT = 2 * LOG_LAT + 2 * EXP_LAT + 6;

    // Per-channel side flags carried along the lane
    typedef struct packed {
        logic sat;
        logic zero;
    } t_flags;

    // Integer square root, elaboration only
    function automatic logic [63:0] pqe_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > x) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-2^-i) in Q30, built by repeated square roots of one half
    function automatic logic [QB:0] pqe_root(input int i);
        logic [63:0] r;
        r = 64'd1 << (QB - 1);
        for (int j = 1; j <= QB; j++) begin
            if (j <= i) r = pqe_isqrt(r << QB);
        end
        return r[QB:0];
    endfunction

    // log2 in Q30 by repeated squaring, elaboration only
    function automatic logic [63:0] pqe_log2q(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] f;
        int          e;
        e = 0;
        f = '0;
        for (int j = 0; j < 64; j++) begin
            if (v[j]) e = j;
        end
        if (e >= QB) m = v >> (e - QB);
        else m = v << (QB - e);
        for (int j = 0; j < QB; j++) begin
            m = (m * m) >> QB;
            f = f << 1;
            if (m >= (64'd2 << QB)) begin
                m = m >> 1;
                f = f | 64'd1;
            end
        end
        if (v == 64'd0) return '0;
        return (64'(e) << QB) | f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pqe_log2.sv =====
`default_nettype none
// Pipelined log2: leading-one detect, normalize, then one squaring per stage
module pqe_log2 import pqe_pkg::*; #(
    parameter int IN_W = 24,
    parameter int SB_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic [IN_W-1:0]            i_v,
    input  wire logic [SB_W-1:0]            i_sb,
    output logic      [$clog2(IN_W)+QB-1:0] o_log,
    output logic      [SB_W-1:0]            o_sb
);

    localparam int EW = $clog2(IN_W);

    logic [EW-1:0]   n_e;
    logic [IN_W-1:0] r_v0;
    logic [EW-1:0]   r_e0;
    logic [SB_W-1:0] r_sb0;
    logic [IN_W+QB-1:0] w_wide;

    logic [QB:0]     r_m  [0:QB];
    logic [QB-1:0]   r_f  [0:QB];
    logic [EW-1:0]   r_e  [0:QB];
    logic [SB_W-1:0] r_sb [0:QB];

    // top set bit
    always_comb begin
        n_e = '0;
        for (int j = 0; j < IN_W; j++) begin
            if (i_v[j]) n_e = EW'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0  <= i_v;
        r_e0  <= n_e;
        r_sb0 <= i_sb;
    end

    // mantissa scaled to [1,2) in Q30
    assign w_wide = {r_v0, {QB{1'b0}}} >> r_e0;

    always_ff @(posedge i_clk) begin
        r_m[0]  <= w_wide[QB:0];
        r_f[0]  <= '0;
        r_e[0]  <= r_e0;
        r_sb[0] <= r_sb0;
    end

    // one fraction bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_sq
        logic [2*QB+1:0] w_sq;
        logic [QB+1:0]   w_s;
        assign w_sq = r_m[k] * r_m[k];
        assign w_s  = w_sq[2*QB+1:QB];
        always_ff @(posedge i_clk) begin
            r_m[k+1]  <= w_s[QB+1] ? w_s[QB+1:1] : w_s[QB:0];
            r_f[k+1]  <= {r_f[k][QB-2:0], w_s[QB+1]};
            r_e[k+1]  <= r_e[k];
            r_sb[k+1] <= r_sb[k];
        end
    end

    assign o_log = {r_e[QB], r_f[QB]};
    assign o_sb  = r_sb[QB];

endmodule
`default_nettype wire

// ===== rtl/pqe_exp2.sv =====
`default_nettype none
// Pipelined 2^(-t): one root multiply per fraction bit, then shift by integer part
module pqe_exp2 import pqe_pkg::*; #(
    parameter int T_W  = 34,
    parameter int SB_W = 1
) (
    input  wire logic            i_clk,
    input  wire logic [T_W-1:0]  i_t,
    input  wire logic [SB_W-1:0] i_sb,
    output logic      [QB:0]     o_r,
    output logic      [SB_W-1:0] o_sb
);

    localparam int KW = T_W - QB;
    localparam logic [QB:0]     ONE  = (QB+1)'(1) << QB;
    localparam logic [2*QB+1:0] HALF = (2*QB+2)'(1) << (QB - 1);

    logic [QB:0]     r_r  [1:QB];
    logic [QB-1:0]   r_f  [1:QB];
    logic [KW-1:0]   r_k  [1:QB];
    logic [SB_W-1:0] r_sb [1:QB];
    logic [QB:0]     r_out;
    logic [SB_W-1:0] r_osb;

    for (genvar i = 1; i <= QB; i++) begin : g_mul
        localparam logic [QB:0] ROOT = pqe_root(i);
        logic [QB:0]     w_pr;
        logic [QB-1:0]   w_pf;
        logic [KW-1:0]   w_pk;
        logic [SB_W-1:0] w_psb;
        logic [2*QB+1:0] w_prod;
        if (i == 1) begin : g_first
            assign w_pr  = ONE;
            assign w_pf  = i_t[QB-1:0];
            assign w_pk  = i_t[T_W-1:QB];
            assign w_psb = i_sb;
        end else begin : g_next
            assign w_pr  = r_r[i-1];
            assign w_pf  = r_f[i-1];
            assign w_pk  = r_k[i-1];
            assign w_psb = r_sb[i-1];
        end
        // rounded product with the root of this bit
        assign w_prod = w_pr * ROOT + HALF;
        always_ff @(posedge i_clk) begin
            r_r[i]  <= w_pf[QB-i] ? w_prod[2*QB:QB] : w_pr;
            r_f[i]  <= w_pf;
            r_k[i]  <= w_pk;
            r_sb[i] <= w_psb;
        end
    end

    // integer part: plain right shift, zero when out of range
    always_ff @(posedge i_clk) begin
        if (64'(r_k[QB]) >= 64'd63) r_out <= '0;
        else r_out <= r_r[QB] >> r_k[QB];
        r_osb <= r_sb[QB];
    end

    assign o_r  = r_out;
    assign o_sb = r_osb;

endmodule
`default_nettype wire

// ===== rtl/pqe_lane.sv =====
`default_nettype none
// One color channel: normalize, power m1, rational, power m2, quantize
module pqe_lane import pqe_pkg::*; #(
    parameter int IN_FRAC_BITS = DEF_IN_FRAC_BITS,
    parameter int OUT_BITS     = DEF_OUT_BITS
) (
    input  wire logic                i_clk,
    input  wire logic [NITS_W-1:0]   i_nits,
    output logic      [OUT_BITS-1:0] o_code
);

    localparam logic [63:0]         TOP  = 64'd10000 << IN_FRAC_BITS;
    localparam logic [63:0]         LT64 = pqe_log2q(TOP);
    localparam logic [35:0]         LT   = LT64[35:0];
    localparam logic [OUT_BITS-1:0] FULL = '1;
    localparam int LX_W = $clog2(NITS_W) + QB;
    localparam int LN_W = $clog2(48) + QB;

    t_flags w_fin;
    logic [LX_W-1:0] w_lx;
    t_flags w_f1;

    logic [35:0] r_neg;
    t_flags      r_fa;
    logic [47:0] w_tp;
    logic [33:0] r_t;
    t_flags      r_fb;

    logic [QB:0] w_p;
    logic [1:0]  w_f2;
    logic [QB:0] w_pz;
    logic [47:0] r_num;
    logic [47:0] r_den;
    t_flags      r_fn;

    logic [LN_W-1:0] w_ln;
    logic [LN_W-1:0] w_ld;
    logic            w_sat3;
    logic            w_zero3;
    logic [35:0]     r_negr;
    t_flags          r_fd;
    logic [47:0]     w_up;
    logic [42:0]     r_u;
    t_flags          r_fu;

    logic [QB:0]     w_e;
    logic [1:0]      w_f4;
    t_flags          w_fe;
    logic [47:0]     w_cp;
    logic [OUT_BITS-1:0] r_code;

    assign w_fin.sat  = (64'(i_nits) >= TOP);
    assign w_fin.zero = (i_nits == '0);

    // log2 of the light level
    pqe_log2 #(.IN_W(NITS_W), .SB_W($bits(t_flags))) u_log_x (
        .i_clk (i_clk),
        .i_v   (i_nits),
        .i_sb  (w_fin),
        .o_log (w_lx),
        .o_sb  (w_f1)
    );

    // distance below full scale
    always_ff @(posedge i_clk) begin
        r_neg <= (LT > 36'(w_lx)) ? LT - 36'(w_lx) : '0;
        r_fa  <= w_f1;
    end

    // times m1, rounded
    assign w_tp = 48'(r_neg) * 48'd2610 + 48'd8192;
    always_ff @(posedge i_clk) begin
        r_t  <= w_tp[47:14];
        r_fb <= r_fa;
    end

    // p = n^m1
    pqe_exp2 #(.T_W(34), .SB_W($bits(t_flags))) u_exp_p (
        .i_clk (i_clk),
        .i_t   (r_t),
        .i_sb  (r_fb),
        .o_r   (w_p),
        .o_sb  (w_f2)
    );

    // numerator and denominator, both scaled by 4096
    assign w_pz = w_f2[0] ? '0 : w_p;
    always_ff @(posedge i_clk) begin
        r_num <= (48'd3424 << QB) + 48'(w_pz) * 48'd77216;
        r_den <= (48'd4096 << QB) + 48'(w_pz) * 48'd76544;
        r_fn  <= w_f2;
    end

    pqe_log2 #(.IN_W(48), .SB_W(1)) u_log_num (
        .i_clk (i_clk),
        .i_v   (r_num),
        .i_sb  (r_fn.sat),
        .o_log (w_ln),
        .o_sb  (w_sat3)
    );

    pqe_log2 #(.IN_W(48), .SB_W(1)) u_log_den (
        .i_clk (i_clk),
        .i_v   (r_den),
        .i_sb  (r_fn.zero),
        .o_log (w_ld),
        .o_sb  (w_zero3)
    );

    // log of the ratio, clamped at zero
    always_ff @(posedge i_clk) begin
        r_negr    <= (w_ld > w_ln) ? 36'(w_ld - w_ln) : '0;
        r_fd.sat  <= w_sat3;
        r_fd.zero <= w_zero3;
    end

    // times m2, rounded
    assign w_up = 48'(r_negr) * 48'd2523 + 48'd16;
    always_ff @(posedge i_clk) begin
        r_u  <= w_up[47:5];
        r_fu <= r_fd;
    end

    pqe_exp2 #(.T_W(43), .SB_W($bits(t_flags))) u_exp_e (
        .i_clk (i_clk),
        .i_t   (r_u),
        .i_sb  (r_fu),
        .o_r   (w_e),
        .o_sb  (w_f4)
    );

    // quantize to full-range code; black and saturation forced
    assign w_fe = w_f4;
    assign w_cp = 48'(w_e) * 48'(FULL) + (48'd1 << (QB - 1));
    always_ff @(posedge i_clk) begin
        if (w_fe.sat) r_code <= FULL;
        else if (w_fe.zero) r_code <= '0;
        else r_code <= w_cp[QB+OUT_BITS-1:QB];
    end

    assign o_code = r_code;

endmodule
`default_nettype wire

// ===== rtl/pq_encode_rgb_pixel.sv =====
`default_nettype none
// PQ (ST 2084) encoder for one RGB pixel per clock.
// o_strobe follows an accepted start through the r_vld shift register and the r_strobe register.
// Throughput: one pixel per cycle; busy is always low, the pipeline is full rate.
// Depth per lane: two 32-stage log2 units, two 31-stage exp2 units, six more registers.
// Reset (synchronous, active low) clears the valid pipeline; the receiver cannot stall.
module pq_encode_rgb_pixel import pqe_pkg::*; #(
    parameter int IN_FRAC_BITS = DEF_IN_FRAC_BITS,
    parameter int OUT_BITS     = DEF_OUT_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [NITS_W-1:0]   i_red_nits,
    input  wire logic [NITS_W-1:0]   i_green_nits,
    input  wire logic [NITS_W-1:0]   i_blue_nits,
    output logic                     o_strobe,
    output logic      [OUT_BITS-1:0] o_red_code,
    output logic      [OUT_BITS-1:0] o_green_code,
    output logic      [OUT_BITS-1:0] o_blue_code
);

    localparam int          TLAT = LANE_LAT + 1;
    localparam logic [63:0] TOP  = 64'd10000 << IN_FRAC_BITS;

    logic [LANE_LAT-1:0] r_vld;
    logic                r_strobe;
    logic [OUT_BITS-1:0] w_red;
    logic [OUT_BITS-1:0] w_green;
    logic [OUT_BITS-1:0] w_blue;
    logic [OUT_BITS-1:0] r_red;
    logic [OUT_BITS-1:0] r_green;
    logic [OUT_BITS-1:0] r_blue;

    assign busy = 1'b0;

    pqe_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lane_r (
        .i_clk (i_clk), .i_nits (i_red_nits), .o_code (w_red)
    );
    pqe_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lane_g (
        .i_clk (i_clk), .i_nits (i_green_nits), .o_code (w_green)
    );
    pqe_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lane_b (
        .i_clk (i_clk), .i_nits (i_blue_nits), .o_code (w_blue)
    );

    // valid tracking for each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[LANE_LAT-2:0], start & ~busy};
            r_strobe <= r_vld[LANE_LAT-1];
        end
    end

    // merge the three lanes into one result
    always_ff @(posedge i_clk) begin
        r_red   <= w_red;
        r_green <= w_green;
        r_blue  <= w_blue;
    end

    assign o_strobe     = r_strobe;
    assign o_red_code   = r_red;
    assign o_green_code = r_green;
    assign o_blue_code  = r_blue;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##TLAT o_strobe)
        else $error("accepted pixel produced no result");

    a_strobe_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, TLAT))
        else $error("result without an accepted pixel");

    a_red_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (64'(i_red_nits) >= TOP) |-> ##TLAT (o_red_code == '1))
        else $error("red above full scale did not saturate");

endmodule
`default_nettype wire

// ===== bench/pqe_checker.sv =====
`timescale 1ns / 100ps
module pqe_checker import pqe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [NITS_W-1:0] i_red_nits,
    input  wire logic [NITS_W-1:0] i_green_nits,
    input  wire logic [NITS_W-1:0] i_blue_nits,
    input  wire logic              o_strobe,
    input  wire logic [11:0]       o_red_code,
    input  wire logic [11:0]       o_green_code,
    input  wire logic [11:0]       o_blue_code,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_pixels_done
);

    localparam int FRAC = DEF_IN_FRAC_BITS;
    localparam int OBITS = DEF_OUT_BITS;
    localparam logic [63:0] ONE = 64'd1 << QB;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
    } t_codes;

    t_codes        code_fifo[$];
    logic [63:0]   half_roots[QB+1];

    // Square root by bit pairs
    function automatic logic [63:0] sqrt_u64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem = v;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q30 log2 by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] v);
        logic [63:0] mant;
        logic [63:0] fr;
        int          msb;
        msb = 0;
        fr = '0;
        if (v == 0) return '0;
        for (int j = 0; j < 64; j++) if (v[j]) msb = j;
        mant = (msb >= QB) ? v >> (msb - QB) : v << (QB - msb);
        for (int j = 0; j < QB; j++) begin
            mant = (mant * mant) >> QB;
            fr = fr << 1;
            if (mant >= (64'd2 << QB)) begin
                mant = mant >> 1;
                fr[0] = 1'b1;
            end
        end
        return (64'(msb) << QB) | fr;
    endfunction

    // 2^-t for Q30 t
    function automatic logic [63:0] pow2_neg(input logic [63:0] t);
        logic [63:0] ip;
        logic [63:0] fr;
        logic [63:0] acc;
        ip = t >> QB;
        fr = t & (ONE - 1);
        acc = ONE;
        if (ip >= 63) return '0;
        for (int j = 1; j <= QB; j++)
            if (fr[QB-j]) acc = (acc * half_roots[j] + (64'd1 << (QB - 1))) >> QB;
        return acc >> ip;
    endfunction

    function automatic logic [11:0] pq_code(input logic [NITS_W-1:0] nits);
        logic [63:0] full;
        logic [63:0] ceil_nits;
        logic [63:0] lin;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] lnum;
        logic [63:0] lden;
        logic [63:0] lt;
        logic [63:0] lx;
        logic [63:0] diff;
        logic [63:0] e;
        full = (64'd1 << OBITS) - 1;
        ceil_nits = 64'd10000 << FRAC;
        lin = '0;
        if (64'(nits) >= ceil_nits) return full[11:0];
        if (nits != 0) begin
            lt = log2_q30(ceil_nits);
            lx = log2_q30(64'(nits));
            diff = (lt > lx) ? lt - lx : 64'd0;
            lin = pow2_neg((diff * 2610 + 8192) >> 14);
        end
        num = 64'd3424 * ONE + 64'd77216 * lin;
        den = 64'd4096 * ONE + 64'd76544 * lin;
        lnum = log2_q30(num);
        lden = log2_q30(den);
        diff = (lden > lnum) ? lden - lnum : 64'd0;
        e = pow2_neg((diff * 2523 + 16) >> 5);
        return 12'(((e * full + (64'd1 << (QB - 1))) >> QB) & full);
    endfunction

    initial begin
        half_roots[0] = ONE >> 1;
        for (int j = 1; j <= QB; j++) half_roots[j] = sqrt_u64(half_roots[j-1] << QB);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pixels_done = 0;
        o_pending = 0;
    end

    // Predict on every input transfer, compare on every strobe
    always @(posedge i_clk) begin
        t_codes want;
        if (i_rst_n && start && !busy)
            code_fifo.push_back('{pq_code(i_red_nits), pq_code(i_green_nits),
                                  pq_code(i_blue_nits)});
        if (i_rst_n && o_strobe) begin
            o_pixels_done++;
            if (code_fifo.size() == 0) begin
                report_mismatch("unexpected pixel", 0, 0);
            end else begin
                want = code_fifo.pop_front();
                if (o_red_code != want.red) report_mismatch("red", o_red_code, want.red);
                if (o_green_code != want.green)
                    report_mismatch("green", o_green_code, want.green);
                if (o_blue_code != want.blue) report_mismatch("blue", o_blue_code, want.blue);
            end
        end
        o_pending <= code_fifo.size();
    end

endmodule

// ===== bench/tb_pq_encode_rgb_pixel.sv =====
`timescale 1ns / 100ps
module tb_pq_encode_rgb_pixel import pqe_pkg::*;;

    localparam int TOP_NITS = 10000 << DEF_IN_FRAC_BITS;
    localparam int CYCLE_LIMIT = 60000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [NITS_W-1:0] i_red_nits = '0;
    logic [NITS_W-1:0] i_green_nits = '0;
    logic [NITS_W-1:0] i_blue_nits = '0;
    logic              o_strobe;
    logic [11:0]       o_red_code;
    logic [11:0]       o_green_code;
    logic [11:0]       o_blue_code;
    int                fail_count;
    int                pending;
    int                pixels_done;
    int                cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pq_encode_rgb_pixel u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_red_nits, .i_green_nits, .i_blue_nits,
        .o_strobe, .o_red_code, .o_green_code, .o_blue_code
    );

    pqe_checker u_check (
        .i_clk, .i_rst_n, .start, .busy, .i_red_nits, .i_green_nits, .i_blue_nits,
        .o_strobe, .o_red_code, .o_green_code, .o_blue_code,
        .o_errors(fail_count), .o_pending(pending), .o_pixels_done(pixels_done)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Pick a channel value: mostly in range, log-spread, some extremes
    function automatic logic [NITS_W-1:0] pick_nits();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return NITS_W'($urandom_range(TOP_NITS - 2, TOP_NITS + 2));
            2: return NITS_W'($urandom);
            3: return NITS_W'($urandom_range(1, 64));
            default: return NITS_W'($urandom_range(1, TOP_NITS - 1) >> $urandom_range(0, 20));
        endcase
    endfunction

    // One pixel transfer; gap_pct is the chance of an idle cycle before it
    task automatic send_pixel(input logic [NITS_W-1:0] r, input logic [NITS_W-1:0] g,
                              input logic [NITS_W-1:0] b, input int gap_pct);
        while ($urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_red_nits <= r;
        i_green_nits <= g;
        i_blue_nits <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic [NITS_W-1:0] edge_vals[10];
        int                gap;
        edge_vals = '{24'd0, 24'd1, 24'd2, 24'd1024, NITS_W'(TOP_NITS - 1),
                      NITS_W'(TOP_NITS), NITS_W'(TOP_NITS + 1),
                      24'hFFFFFF, 24'hAAAAAA, 24'h555555};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, saturation boundary, all-ones and toggling bit patterns
        for (int j = 0; j < 10; j++)
            send_pixel(edge_vals[j], edge_vals[(j + 3) % 10], edge_vals[(j + 7) % 10], 0);
        start <= 1'b0;
        // Let the pipe drain fully once
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);

        // Random pixels across idling phases
        for (int j = 0; j < 800; j++) begin
            case (j / 200)
                0: gap = 0;
                1: gap = 76;
                2: gap = 13;
                default: gap = (j % 50 < 25) ? 0 : 76;
            endcase
            send_pixel(pick_nits(), pick_nits(), pick_nits(), gap);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
        $display("covered %0d pixels: zero, saturation edge, full 24-bit range, gaps",
                 pixels_done);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
